// ----- rtl/pae_pkg.sv -----
package pae_pkg;

    localparam int SQRT_STAGES = 33;
    localparam int DIV_STAGES  = 17;
    localparam int RAT_STAGES  = 24;

    localparam logic [15:0] RST_TARGET_X = 16'd0;
    localparam logic [15:0] RST_TARGET_Y = 16'd0;
    localparam logic [15:0] RST_FRAME_T  = 16'd1092;
    localparam logic [15:0] RST_DAMP_DIV = 16'd2560;
    localparam logic [15:0] RST_SPEED    = 16'd1024;

    typedef enum logic [2:0] {
        CFG_TARGET_X = 3'd0,
        CFG_TARGET_Y = 3'd1,
        CFG_FRAME_T  = 3'd2,
        CFG_DAMP_DIV = 3'd3,
        CFG_SPEED    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [31:0]        ax;
        logic [31:0]        ay;
        logic               sx;
        logic               sy;
    } t_item;

    function automatic logic signed [31:0] sat32(input logic signed [42:0] x);
        logic signed [31:0] res;
        if (x > 43'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (x < -43'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/particle_attractor_step_unit.sv -----
// channel   | dir | handshake                    | payload
// particles | in  | s_axis_tvalid/s_axis_tready  | s_axis_tdata
// results   | out | m_axis_tvalid/m_axis_tready  | m_axis_tdata
// config    | in  | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// One particle per cycle unless the output stalls; the pipeline holds the 33
// square-root stages and the 17 divide stages of the normalizing path.
// The damping ratio divider runs freely in 24 stages; a config write settles
// before any item accepted after it reaches the damping stage.
// Synchronous active-low reset clears valid bits and loads config defaults.
// Output stall freezes the particle pipeline; s_axis_tready follows it.
module particle_attractor_step_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // pos_x, pos_y, vel_x, vel_y
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,   // new_pos_x, new_pos_y, new_vel_x, new_vel_y
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);

    logic [15:0] r_tx, r_ty, r_ft, r_dd, r_sp;
    logic [31:0] r_gain;
    logic signed [25:0] w_factor;
    logic        w_en;

    assign o_cfg_ready   = 1'b1;
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx <= pae_pkg::RST_TARGET_X;
            r_ty <= pae_pkg::RST_TARGET_Y;
            r_ft <= pae_pkg::RST_FRAME_T;
            r_dd <= pae_pkg::RST_DAMP_DIV;
            r_sp <= pae_pkg::RST_SPEED;
        end else if (i_cfg_valid) begin
            case (pae_pkg::t_cfg_idx'(i_cfg_index))
                pae_pkg::CFG_TARGET_X: r_tx <= i_cfg_data;
                pae_pkg::CFG_TARGET_Y: r_ty <= i_cfg_data;
                pae_pkg::CFG_FRAME_T:  r_ft <= i_cfg_data;
                pae_pkg::CFG_DAMP_DIV: r_dd <= i_cfg_data;
                pae_pkg::CFG_SPEED:    r_sp <= i_cfg_data;
                default: ;
            endcase
        end
        r_gain <= r_ft * r_sp;
    end

    pae_ratio u_ratio (
        .i_clk      (i_clk),
        .i_frame_t  (r_ft),
        .i_damp_div (r_dd),
        .o_factor   (w_factor)
    );

    // distance vector
    logic signed [31:0] w_px, w_py;
    logic signed [33:0] w_dx, w_dy, w_adx, w_ady;
    assign w_px  = s_axis_tdata[31:0];
    assign w_py  = s_axis_tdata[63:32];
    assign w_dx  = {{2{r_tx[15]}}, r_tx, 16'h0} - {{2{w_px[31]}}, w_px};
    assign w_dy  = {{2{r_ty[15]}}, r_ty, 16'h0} - {{2{w_py[31]}}, w_py};
    assign w_adx = w_dx[33] ? -w_dx : w_dx;
    assign w_ady = w_dy[33] ? -w_dy : w_dy;

    logic           r1_vld;
    pae_pkg::t_item r1_item;
    logic           r2_vld;
    pae_pkg::t_item r2_item;
    logic [63:0]    r2_sqx, r2_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= s_axis_tvalid;
            r2_vld <= r1_vld;
        end
        if (w_en) begin
            r1_item.px <= w_px;
            r1_item.py <= w_py;
            r1_item.vx <= s_axis_tdata[95:64];
            r1_item.vy <= s_axis_tdata[127:96];
            r1_item.ax <= w_adx[31:0];
            r1_item.ay <= w_ady[31:0];
            r1_item.sx <= w_dx[33];
            r1_item.sy <= w_dy[33];
            r2_item    <= r1_item;
            r2_sqx     <= r1_item.ax * r1_item.ax;
            r2_sqy     <= r1_item.ay * r1_item.ay;
        end
    end

    logic           w_sq_vld;
    logic [32:0]    w_len;
    pae_pkg::t_item w_sq_item;

    pae_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r2_vld),
        .i_sum   ({2'b00, r2_sqx} + {2'b00, r2_sqy}),
        .i_item  (r2_item),
        .o_vld   (w_sq_vld),
        .o_root  (w_len),
        .o_item  (w_sq_item)
    );

    logic           w_dv_vld;
    logic [16:0]    w_qx, w_qy;
    pae_pkg::t_item w_dv_item;

    pae_udiv u_udiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_sq_vld),
        .i_len   (w_len),
        .i_item  (w_sq_item),
        .o_vld   (w_dv_vld),
        .o_qx    (w_qx),
        .o_qy    (w_qy),
        .o_item  (w_dv_item)
    );

    // damping multiply
    logic                rd_vld;
    logic signed [31:0]  rd_px, rd_py;
    logic signed [17:0]  rd_nx, rd_ny;
    logic signed [57:0]  rd_mx, rd_my;

    // velocity sum
    logic                re_vld;
    logic signed [31:0]  re_px, re_py, re_vx, re_vy;
    logic signed [42:0]  w_vx, w_vy;
    assign w_vx = 43'(rd_mx >>> 16) + 43'(rd_nx);
    assign w_vy = 43'(rd_my >>> 16) + 43'(rd_ny);

    // advance multiply
    logic                rf_vld;
    logic signed [31:0]  rf_px, rf_py, rf_vx, rf_vy;
    logic signed [64:0]  rf_ax, rf_ay;

    logic signed [42:0]  w_npx, w_npy;
    assign w_npx = 43'(rf_ax >>> 24) + 43'(rf_px);
    assign w_npy = 43'(rf_ay >>> 24) + 43'(rf_py);

    logic [127:0] r_odata;
    logic         r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_vld <= 1'b0;
            re_vld <= 1'b0;
            rf_vld <= 1'b0;
            r_ovld <= 1'b0;
        end else if (w_en) begin
            rd_vld <= w_dv_vld;
            re_vld <= rd_vld;
            rf_vld <= re_vld;
            r_ovld <= rf_vld;
        end
        if (w_en) begin
            rd_px <= w_dv_item.px;
            rd_py <= w_dv_item.py;
            rd_nx <= w_dv_item.sx ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
            rd_ny <= w_dv_item.sy ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
            rd_mx <= w_dv_item.vx * w_factor;
            rd_my <= w_dv_item.vy * w_factor;
            re_px <= rd_px;
            re_py <= rd_py;
            re_vx <= pae_pkg::sat32(w_vx);
            re_vy <= pae_pkg::sat32(w_vy);
            rf_px <= re_px;
            rf_py <= re_py;
            rf_vx <= re_vx;
            rf_vy <= re_vy;
            rf_ax <= re_vx * $signed({1'b0, r_gain});
            rf_ay <= re_vy * $signed({1'b0, r_gain});
            r_odata <= {rf_vy, rf_vx, pae_pkg::sat32(w_npy), pae_pkg::sat32(w_npx)};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    a_unit_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_vld |-> (w_qx <= 17'd65536 && w_qy <= 17'd65536))
        else $error("normalized component exceeds one");

    a_factor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_vld |-> w_factor <= 26'sd65536)
        else $error("damping factor above one");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(rd_vld) && $stable(re_vld) && $stable(rf_vld))
        else $error("pipeline moved during stall");

    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sq_vld && w_len == '0) |-> (w_sq_item.ax == '0 && w_sq_item.ay == '0))
        else $error("zero length with nonzero distance");

endmodule

// ----- rtl/pae_isqrt.sv -----
module pae_isqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [65:0]         i_sum,
    input  pae_pkg::t_item      i_item,
    output logic                o_vld,
    output logic [32:0]         o_root,
    output pae_pkg::t_item      o_item
);

    localparam int NS = pae_pkg::SQRT_STAGES;

    logic [35:0]    r_rem  [NS];
    logic [32:0]    r_root [NS];
    logic [65:0]    r_rad  [NS];
    pae_pkg::t_item r_item [NS];
    logic [NS-1:0]  r_vld;

    logic [35:0]    n_rem  [NS];
    logic [32:0]    n_root [NS];
    logic [65:0]    n_rad  [NS];

    logic [35:0] pr;
    logic [32:0] pt;
    logic [65:0] pd;
    logic [35:0] cur;
    logic [35:0] trial;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                pr = '0;
                pt = '0;
                pd = i_sum;
            end else begin
                pr = r_rem[k-1];
                pt = r_root[k-1];
                pd = r_rad[k-1];
            end
            cur   = {pr[33:0], pd[65:64]};
            trial = {1'b0, pt, 2'b01};
            n_rad[k] = {pd[63:0], 2'b00};
            if (cur >= trial) begin
                n_rem[k]  = cur - trial;
                n_root[k] = {pt[31:0], 1'b1};
            end else begin
                n_rem[k]  = cur;
                n_root[k] = {pt[31:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
                r_item[k] <= (k == 0) ? i_item : r_item[k-1];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_root = r_root[NS-1];
    assign o_item = r_item[NS-1];

endmodule

// ----- rtl/pae_udiv.sv -----
module pae_udiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [32:0]         i_len,
    input  pae_pkg::t_item      i_item,
    output logic                o_vld,
    output logic [16:0]         o_qx,
    output logic [16:0]         o_qy,
    output pae_pkg::t_item      o_item
);

    localparam int NS = pae_pkg::DIV_STAGES;

    logic [47:0]    r_rx  [NS];
    logic [47:0]    r_ry  [NS];
    logic [16:0]    r_qx  [NS];
    logic [16:0]    r_qy  [NS];
    logic [32:0]    r_len [NS];
    pae_pkg::t_item r_item[NS];
    logic [NS-1:0]  r_vld;

    logic [47:0]    n_rx [NS];
    logic [47:0]    n_ry [NS];
    logic [16:0]    n_qx [NS];
    logic [16:0]    n_qy [NS];

    logic [47:0] prx, pry;
    logic [16:0] pqx, pqy;
    logic [32:0] pl;
    logic [48:0] dsh;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                prx = {i_item.ax, 16'h0};
                pry = {i_item.ay, 16'h0};
                pqx = '0;
                pqy = '0;
                pl  = i_len;
            end else begin
                prx = r_rx[k-1];
                pry = r_ry[k-1];
                pqx = r_qx[k-1];
                pqy = r_qy[k-1];
                pl  = r_len[k-1];
            end
            dsh = 49'(pl) << (NS - 1 - k);
            n_rx[k] = prx;
            n_ry[k] = pry;
            n_qx[k] = pqx;
            n_qy[k] = pqy;
            if (pl != '0 && {1'b0, prx} >= dsh) begin
                n_rx[k] = prx - dsh[47:0];
                n_qx[k][NS-1-k] = 1'b1;
            end
            if (pl != '0 && {1'b0, pry} >= dsh) begin
                n_ry[k] = pry - dsh[47:0];
                n_qy[k][NS-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_vld};
        end
        if (i_en) begin
            for (int k = 0; k < NS; k++) begin
                r_rx[k]   <= n_rx[k];
                r_ry[k]   <= n_ry[k];
                r_qx[k]   <= n_qx[k];
                r_qy[k]   <= n_qy[k];
                r_len[k]  <= (k == 0) ? i_len : r_len[k-1];
                r_item[k] <= (k == 0) ? i_item : r_item[k-1];
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_qx   = r_qx[NS-1];
    assign o_qy   = r_qy[NS-1];
    assign o_item = r_item[NS-1];

endmodule

// ----- rtl/pae_ratio.sv -----
module pae_ratio (
    input  logic               i_clk,
    input  logic [15:0]        i_frame_t,
    input  logic [15:0]        i_damp_div,
    output logic signed [25:0] o_factor
);

    localparam int NS = pae_pkg::RAT_STAGES;

    logic [23:0] r_rem [NS];
    logic [23:0] r_q   [NS];
    logic [15:0] r_dv  [NS];
    logic signed [25:0] r_factor;

    logic [23:0] n_rem [NS];
    logic [23:0] n_q   [NS];

    logic [23:0] pr, pq;
    logic [15:0] pv;
    logic [39:0] dsh;

    always_comb begin
        for (int k = 0; k < NS; k++) begin
            if (k == 0) begin
                pr = {i_frame_t, 8'h0};
                pq = '0;
                pv = (i_damp_div == '0) ? 16'd1 : i_damp_div;
            end else begin
                pr = r_rem[k-1];
                pq = r_q[k-1];
                pv = r_dv[k-1];
            end
            dsh = 40'(pv) << (NS - 1 - k);
            n_rem[k] = pr;
            n_q[k]   = pq;
            if ({16'h0, pr} >= dsh) begin
                n_rem[k] = pr - dsh[23:0];
                n_q[k][NS-1-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            r_rem[k] <= n_rem[k];
            r_q[k]   <= n_q[k];
            r_dv[k]  <= (k == 0) ? ((i_damp_div == '0) ? 16'd1 : i_damp_div) : r_dv[k-1];
        end
        r_factor <= 26'sd65536 - $signed({2'b00, r_q[NS-1]});
    end

    assign o_factor = r_factor;

endmodule
